// File: src/cda_pkg.sv
// Shared types, constants and calendar helper functions for the date counter.
package cda_pkg;

  localparam int unsigned DAY_BITS   = 5;
  localparam int unsigned MONTH_BITS = 4;
  localparam int unsigned YEAR_BITS  = 16;
  localparam int unsigned COUNT_BITS = 10;
  localparam int unsigned YMOD_BITS  = 9;   // holds year mod 400

  typedef logic [DAY_BITS-1:0]   day_t;
  typedef logic [MONTH_BITS-1:0] month_t;
  typedef logic [YEAR_BITS-1:0]  year_t;
  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [YMOD_BITS-1:0]  ymod_t;

  localparam int unsigned LEAP_CYCLE = 400;
  localparam int unsigned CENTURY    = 100;

  localparam day_t   DEF_DAY   = DAY_BITS'(1);
  localparam month_t DEF_MONTH = MONTH_BITS'(1);
  localparam year_t  DEF_YEAR  = YEAR_BITS'(1970);
  localparam ymod_t  DEF_YMOD  = YMOD_BITS'(1970 % LEAP_CYCLE);

  localparam month_t MON_JAN = MONTH_BITS'(1);
  localparam month_t MON_FEB = MONTH_BITS'(2);
  localparam month_t MON_DEC = MONTH_BITS'(12);

  localparam day_t LEN_SHORT = DAY_BITS'(28);
  localparam day_t LEN_LEAP  = DAY_BITS'(29);
  localparam day_t LEN_30    = DAY_BITS'(30);
  localparam day_t LEN_31    = DAY_BITS'(31);
  localparam day_t LEN_NONE  = DAY_BITS'(0);

  // floor(2^22 / 400): quotient estimate is exact or one low for 16-bit years
  localparam int unsigned RECIP_SHIFT = 22;
  localparam int unsigned RECIP_BITS  = 14;
  localparam int unsigned RECIP_400   = (1 << RECIP_SHIFT) / LEAP_CYCLE;
  localparam int unsigned PROD_BITS   = YEAR_BITS + RECIP_BITS;
  localparam int unsigned QUOT_BITS   = PROD_BITS - RECIP_SHIFT;

  typedef logic [QUOT_BITS-1:0] quot_t;

  typedef enum logic [1:0] {
    ACT_LOAD      = 2'd0,
    ACT_ADD_DAYS  = 2'd1,
    ACT_ADD_MONTH = 2'd2,
    ACT_ADD_YEAR  = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LD_MUL,
    ST_LD_REM,
    ST_LD_CHK,
    ST_DAYS,
    ST_MONTH,
    ST_YEAR,
    ST_DONE
  } state_e;

  typedef struct packed {
    action_e action;
    day_t    load_day;
    month_t  load_month;
    year_t   load_year;
    count_t  day_count;
  } cda_in_t;

  typedef struct packed {
    day_t   day;
    month_t month;
    year_t  year;
    logic   load_error;
  } cda_out_t;

  typedef struct packed {
    logic capture;
    logic mul;
    logic rem;
    logic load;
    logic day_step;
    logic month_step;
    logic year_step;
    logic out_load;
  } cda_cmd_t;

  typedef struct packed {
    logic cnt_zero;
  } cda_sts_t;

  // Leap test from year mod 400: 400 is a multiple of 4 and 100.
  function automatic logic is_leap(input ymod_t r);
    logic century;
    century = (r == YMOD_BITS'(CENTURY)) || (r == YMOD_BITS'(2 * CENTURY)) ||
              (r == YMOD_BITS'(3 * CENTURY));
    return (r == '0) || ((r[1:0] == 2'b00) && !century);
  endfunction

  // Days in month m; zero for a month outside 1..12.
  function automatic day_t month_len(input month_t m, input logic leap);
    day_t len;
    len = LEN_NONE;
    if (m inside {4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12}) begin
      len = LEN_31;
    end else if (m inside {4'd4, 4'd6, 4'd9, 4'd11}) begin
      len = LEN_30;
    end else if (m == MON_FEB) begin
      len = leap ? LEN_LEAP : LEN_SHORT;
    end
    return len;
  endfunction

endpackage

// File: src/cda_ctrl.sv
// Controller state machine: sequences load, day, month and year operations.
module cda_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  cda_pkg::action_e   action_i,
  output logic               in_stall_o,
  input  logic               out_stall_i,
  output logic               out_valid_o,
  input  cda_pkg::cda_sts_t  sts_i,
  output cda_pkg::cda_cmd_t  cmd_o
);
  import cda_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          case (action_i)
            ACT_LOAD:      state_d = ST_LD_MUL;
            ACT_ADD_DAYS:  state_d = ST_DAYS;
            ACT_ADD_MONTH: state_d = ST_MONTH;
            ACT_ADD_YEAR:  state_d = ST_YEAR;
            default:       state_d = ST_IDLE;
          endcase
        end
      end
      ST_LD_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_LD_REM;
      end
      ST_LD_REM: begin
        cmd_o.rem = 1'b1;
        state_d   = ST_LD_CHK;
      end
      ST_LD_CHK: begin
        cmd_o.load = 1'b1;
        state_d    = ST_DONE;
      end
      ST_DAYS: begin
        if (sts_i.cnt_zero) begin
          state_d = ST_DONE;
        end else begin
          cmd_o.day_step = 1'b1;
        end
      end
      ST_MONTH: begin
        cmd_o.month_step = 1'b1;
        state_d          = ST_DONE;
      end
      ST_YEAR: begin
        cmd_o.year_step = 1'b1;
        state_d         = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: src/cda_datapath.sv
// Datapath: date registers, leap tracking, load check and result register.
module cda_datapath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cda_pkg::cda_in_t   in_req_i,
  input  cda_pkg::cda_cmd_t  cmd_i,
  output cda_pkg::cda_sts_t  sts_o,
  output cda_pkg::cda_out_t  out_req_o
);
  import cda_pkg::*;

  // Current date plus year mod 400 for the leap rule
  day_t   day_q, day_d;
  month_t month_q, month_d;
  year_t  year_q, year_d;
  ymod_t  ymod_q, ymod_d;
  logic   err_q, err_d;
  count_t cnt_q, cnt_d;

  // Load staging
  day_t     ld_day_q;
  month_t   ld_month_q;
  year_t    ld_year_q;
  quot_t    quot_q;
  ymod_t    rem_q;
  cda_out_t out_q;

  logic [PROD_BITS-1:0] prod;
  year_t  rem_raw;
  year_t  rem_fix;
  logic   leap_cur;
  day_t   len_cur;
  day_t   len_next;
  day_t   len_ld;
  month_t month_inc;
  year_t  year_inc;
  ymod_t  ymod_inc;
  logic   ld_ok;

  assign prod    = PROD_BITS'(ld_year_q) * PROD_BITS'(RECIP_400);
  assign rem_raw = ld_year_q - YEAR_BITS'(YEAR_BITS'(quot_q) * YEAR_BITS'(LEAP_CYCLE));
  assign rem_fix = (rem_raw >= YEAR_BITS'(LEAP_CYCLE)) ?
                   (rem_raw - YEAR_BITS'(LEAP_CYCLE)) : rem_raw;

  assign leap_cur  = is_leap(ymod_q);
  assign len_cur   = month_len(month_q, leap_cur);
  assign month_inc = month_q + MONTH_BITS'(1);
  assign len_next  = month_len(month_inc, leap_cur);
  assign year_inc  = year_q + YEAR_BITS'(1);
  assign ymod_inc  = ((year_inc == '0) || (ymod_q == YMOD_BITS'(LEAP_CYCLE - 1))) ?
                     '0 : (ymod_q + YMOD_BITS'(1));

  assign len_ld = month_len(ld_month_q, is_leap(rem_q));
  assign ld_ok  = (len_ld != LEN_NONE) && (ld_day_q != '0) && (ld_day_q <= len_ld);

  always_comb begin
    day_d   = day_q;
    month_d = month_q;
    year_d  = year_q;
    ymod_d  = ymod_q;
    err_d   = err_q;
    cnt_d   = cnt_q;
    if (cmd_i.capture) begin
      cnt_d = in_req_i.day_count;
    end
    if (cmd_i.load) begin
      if (ld_ok) begin
        day_d   = ld_day_q;
        month_d = ld_month_q;
        year_d  = ld_year_q;
        ymod_d  = rem_q;
        err_d   = 1'b0;
      end else begin
        day_d   = DEF_DAY;
        month_d = DEF_MONTH;
        year_d  = DEF_YEAR;
        ymod_d  = DEF_YMOD;
        err_d   = 1'b1;
      end
    end
    if (cmd_i.day_step) begin
      cnt_d = cnt_q - COUNT_BITS'(1);
      if (day_q >= len_cur) begin
        day_d = DEF_DAY;
        if (month_q == MON_DEC) begin
          month_d = MON_JAN;
          year_d  = year_inc;
          ymod_d  = ymod_inc;
        end else begin
          month_d = month_inc;
        end
      end else begin
        day_d = day_q + DAY_BITS'(1);
      end
    end
    if (cmd_i.month_step) begin
      if (month_q == MON_DEC) begin
        // January is 31 days long, so no clamp after a year rollover
        month_d = MON_JAN;
        year_d  = year_inc;
        ymod_d  = ymod_inc;
      end else begin
        month_d = month_inc;
        if (day_q > len_next) begin
          day_d = len_next;
        end
      end
    end
    if (cmd_i.year_step) begin
      if ((day_q == LEN_LEAP) && (month_q == MON_FEB)) begin
        day_d = LEN_SHORT;
      end
      year_d = year_inc;
      ymod_d = ymod_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      day_q   <= DEF_DAY;
      month_q <= DEF_MONTH;
      year_q  <= DEF_YEAR;
      ymod_q  <= DEF_YMOD;
      err_q   <= 1'b0;
      cnt_q   <= '0;
    end else begin
      day_q   <= day_d;
      month_q <= month_d;
      year_q  <= year_d;
      ymod_q  <= ymod_d;
      err_q   <= err_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      ld_day_q   <= in_req_i.load_day;
      ld_month_q <= in_req_i.load_month;
      ld_year_q  <= in_req_i.load_year;
    end
    if (cmd_i.mul) begin
      quot_q <= prod[PROD_BITS-1:RECIP_SHIFT];
    end
    if (cmd_i.rem) begin
      rem_q <= rem_fix[YMOD_BITS-1:0];
    end
    if (cmd_i.out_load) begin
      out_q.day        <= day_q;
      out_q.month      <= month_q;
      out_q.year       <= year_q;
      out_q.load_error <= err_q;
    end
  end

  assign sts_o.cnt_zero = (cnt_q == '0);
  assign out_req_o      = out_q;

endmodule

// File: src/calendar_date_advance_core.sv
// Top level of the Gregorian calendar date counter.
//
// Holds a date (day, month, year) with Gregorian leap years and answers every
// request with the date after the requested action and the load error flag.
// Reset date is 1.1.1970 with the flag clear. Requests are handled one at a
// time; a finished result sits in an output register, so the next request is
// taken while the previous result still waits. A load reduces the year mod
// 400 with a reciprocal multiply and a remainder fix-up, then checks the
// date; add month and add year step the date directly; add days makes one
// day step per cycle in the datapath's date counter, day_count steps in all.
// A load with a month outside 1..12 or a day of zero or past the month's end
// gives 1.1.1970 and sets load_error; only a load changes that flag. Add
// month clamps the day to the new month's length, add year turns 29
// February into 28 February, and the year wraps from 65535 to 0 (year 0
// counts as a leap year).
module calendar_date_advance_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  cda_pkg::cda_in_t  in_req_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output cda_pkg::cda_out_t out_req_o
);
  import cda_pkg::*;

  cda_cmd_t cmd;
  cda_sts_t sts;

  // Sequencer: one request in flight, result handed off via the output register
  cda_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .action_i    (in_req_i.action),
    .in_stall_o  (in_stall_o),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Date registers, leap tracking and load check
  cda_datapath u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_req_i  (in_req_i),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .out_req_o (out_req_o)
  );

`ifndef SYNTH
  // A request is never taken while the previous one is still being worked on
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("request accepted while busy");

  // At most one date update per cycle
  a_one_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.load, cmd.day_step, cmd.month_step, cmd.year_step}))
    else $error("conflicting date updates");

  // Results always carry a month in 1..12 and a nonzero day
  a_date_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_req_o.month >= MON_JAN) && (out_req_o.month <= MON_DEC) &&
                    (out_req_o.day != '0))
    else $error("illegal date in result");

  // The result register is only reloaded once the old result is gone
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (!out_valid_o || !out_stall_i))
    else $error("result overwritten");
`endif

endmodule
